// ----- design/lgnc_pkg.sv -----
package lgnc_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);

    // request to the row store; one read and one write port
    typedef struct packed {
        logic                rd_en;
        logic [ROW_W-1:0]    rd_addr;
        logic                wr_en;
        logic [ROW_W-1:0]    wr_addr;
        logic [MAX_COLS-1:0] wr_data;
    } mem_req_t;

endpackage

// ----- design/life_grid_neighbor_census.sv -----
// Cell grid with Moore-neighbor census.
// Input channel s_*: one request item per handshake, tdata = {col, row, func}.
//   func: set live, set dead, get cell, census of the eight neighbors.
// Result channel m_*: one result item per request, tdata = {in_bounds,
//   live_neighbors, cell_live}. Results come in request order.
// Config channel cfg_*: index 0 grid_rows, 1 grid_cols, 2 wrap_edges; always
//   ready, write only while no request is in flight.
// Cells live in a row-wide memory, one port read and one written per cycle.
// Set and get step through read row, modify or pick the bit, and load result;
// census runs three row reads through the memory port, pipelined with one
// shared 3-bit count-and-add unit, and then loads the result.
// Out-of-bounds requests skip the memory. s_tready is high only while no
// request is in flight, so one item is worked at a time.
// A finished result waits in the output register while m_tready is low; the
// next request may still be accepted and is held before the load step.
// Reset (aresetn low, synchronous) marks every row dead, restores 64x64
// bounded grid and empties the output register.
module life_grid_neighbor_census (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] func, [8:2] row, [15:9] col
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] cell_live, [4:1] live_neighbors, [5] in_bounds
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import lgnc_pkg::*;

    localparam logic [1:0] FN_SET_LIVE = 2'd0;
    localparam logic [1:0] FN_SET_DEAD = 2'd1;
    localparam logic [1:0] FN_GET      = 2'd2;
    localparam logic [1:0] FN_CENSUS   = 2'd3;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_WRAP = 2'd2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ONE  = 3'd1;
    localparam logic [2:0] ST_MOD  = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [6:0] ROWS_CAP = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);
    localparam logic [6:0] COLS_CAP = (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);

    logic [6:0] rows_cfg_reg;
    logic [6:0] cols_cfg_reg;
    logic       wrap_reg;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] func_reg;
    logic [ROW_W-1:0] row_c_reg, row_u_reg, row_d_reg;
    logic [COL_W-1:0] col_c_reg, col_l_reg, col_r_reg;
    logic       up_ok_reg, dn_ok_reg, l_ok_reg, r_ok_reg;
    logic [3:0] acc_reg, acc_next;
    logic       live_reg, live_next;
    logic       inb_reg;

    logic       out_vld_reg;
    logic [7:0] out_data_reg;

    logic [1:0] in_func;
    logic [6:0] in_row, in_col;
    logic [6:0] rows_eff, cols_eff;
    logic       in_inb;
    logic       s_fire;
    logic       out_load;

    mem_req_t            mreq;
    logic [MAX_COLS-1:0] rd_data;
    logic [MAX_COLS-1:0] wr_word;

    logic [1:0] slot;
    logic       slot_ok, slot_center;
    logic       bit_l, bit_c, bit_r;
    logic [1:0] row_sum;

    assign in_func = s_tdata[1:0];
    assign in_row  = s_tdata[8:2];
    assign in_col  = s_tdata[15:9];

    always_comb begin
        if (rows_cfg_reg == 7'd0) begin
            rows_eff = 7'd1;
        end else if (rows_cfg_reg > ROWS_CAP) begin
            rows_eff = ROWS_CAP;
        end else begin
            rows_eff = rows_cfg_reg;
        end
        if (cols_cfg_reg == 7'd0) begin
            cols_eff = 7'd1;
        end else if (cols_cfg_reg > COLS_CAP) begin
            cols_eff = COLS_CAP;
        end else begin
            cols_eff = cols_cfg_reg;
        end
    end

    assign in_inb    = (in_row < rows_eff) && (in_col < cols_eff);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_DONE) && (!out_vld_reg || m_tready);

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= 7'd64;
            cols_cfg_reg <= 7'd64;
            wrap_reg     <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ROWS: rows_cfg_reg <= cfg_data;
                REG_COLS: cols_cfg_reg <= cfg_data;
                REG_WRAP: wrap_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // request capture and neighbor coordinates
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg  <= in_func;
            inb_reg   <= in_inb;
            row_c_reg <= ROW_W'(in_row);
            col_c_reg <= COL_W'(in_col);
            if (in_row == 7'd0) begin
                row_u_reg <= ROW_W'(rows_eff - 7'd1);
                up_ok_reg <= wrap_reg;
            end else begin
                row_u_reg <= ROW_W'(in_row - 7'd1);
                up_ok_reg <= 1'b1;
            end
            if (in_row + 7'd1 == rows_eff) begin
                row_d_reg <= '0;
                dn_ok_reg <= wrap_reg;
            end else begin
                row_d_reg <= ROW_W'(in_row + 7'd1);
                dn_ok_reg <= 1'b1;
            end
            if (in_col == 7'd0) begin
                col_l_reg <= COL_W'(cols_eff - 7'd1);
                l_ok_reg  <= wrap_reg;
            end else begin
                col_l_reg <= COL_W'(in_col - 7'd1);
                l_ok_reg  <= 1'b1;
            end
            if (in_col + 7'd1 == cols_eff) begin
                col_r_reg <= '0;
                r_ok_reg  <= wrap_reg;
            end else begin
                col_r_reg <= COL_W'(in_col + 7'd1);
                r_ok_reg  <= 1'b1;
            end
        end
    end

    // shared count unit: slot 0 row above, 1 own row, 2 row below
    assign slot = cnt_reg - 2'd1;
    always_comb begin
        unique case (slot)
            2'd0:    slot_ok = up_ok_reg;
            2'd2:    slot_ok = dn_ok_reg;
            default: slot_ok = 1'b1;
        endcase
    end
    assign slot_center = (slot == 2'd1);
    assign bit_l   = slot_ok && l_ok_reg && rd_data[col_l_reg];
    assign bit_c   = slot_ok && !slot_center && rd_data[col_c_reg];
    assign bit_r   = slot_ok && r_ok_reg && rd_data[col_r_reg];
    assign row_sum = {1'b0, bit_l} + {1'b0, bit_c} + {1'b0, bit_r};

    always_comb begin
        wr_word = rd_data;
        wr_word[col_c_reg] = (func_reg == FN_SET_LIVE);
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        live_next     = live_reg;
        mreq.rd_en    = 1'b0;
        mreq.rd_addr  = row_c_reg;
        mreq.wr_en    = 1'b0;
        mreq.wr_addr  = row_c_reg;
        mreq.wr_data  = wr_word;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    acc_next  = 4'd0;
                    live_next = 1'b0;
                    cnt_next  = 2'd0;
                    if (!in_inb) begin
                        state_next = ST_DONE;
                    end else if (in_func == FN_CENSUS) begin
                        state_next = ST_RUN;
                    end else begin
                        state_next = ST_ONE;
                    end
                end
            end
            ST_ONE: begin
                mreq.rd_en = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                if (func_reg == FN_GET) begin
                    live_next = rd_data[col_c_reg];
                end else begin
                    mreq.wr_en = (func_reg == FN_SET_LIVE) || (func_reg == FN_SET_DEAD);
                end
                state_next = ST_DONE;
            end
            ST_RUN: begin
                unique case (cnt_reg)
                    2'd0:    mreq.rd_addr = row_u_reg;
                    2'd1:    mreq.rd_addr = row_c_reg;
                    default: mreq.rd_addr = row_d_reg;
                endcase
                mreq.rd_en = (cnt_reg != 2'd3);
                if (cnt_reg != 2'd0) begin
                    acc_next = acc_reg + {2'b00, row_sum};
                end
                if (cnt_reg == 2'd3) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        live_reg <= live_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {2'b00, inb_reg, acc_reg, live_reg};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    lgnc_row_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rd_data (rd_data)
    );

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg != ST_IDLE)
        else $error("accepted item did not start work");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[4:1] <= 4'd8)
        else $error("neighbor count above eight");

    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[5] |-> m_tdata[4:0] == 5'd0)
        else $error("out-of-bounds result not zero");

    a_live_or_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && (m_tdata[4:1] != 4'd0)))
        else $error("get and census fields both set");

    a_no_write_in_census: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> !mreq.wr_en)
        else $error("store write during census");
`endif

endmodule

// ----- design/lgnc_row_store.sv -----
module lgnc_row_store (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lgnc_pkg::mem_req_t      req,
    output logic [lgnc_pkg::MAX_COLS-1:0] rd_data
);
    import lgnc_pkg::*;

    logic [MAX_COLS-1:0] row_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_vld_reg;
    logic [MAX_ROWS-1:0] row_vld_next;
    logic [MAX_COLS-1:0] rd_word_reg;
    logic                rd_vld_reg;

    always_comb begin
        row_vld_next = row_vld_reg;
        if (req.wr_en) begin
            row_vld_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else begin
            row_vld_reg <= row_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            row_mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_word_reg <= row_mem[req.rd_addr];
            rd_vld_reg  <= row_vld_reg[req.rd_addr];
        end
    end

    // rows never written since reset read as all dead
    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule
